// ===== hdl/sbsm_pkg.sv =====
package sbsm_pkg;

  // Bus access kinds carried on the slave-side tuser
  typedef enum logic [1:0] {
    ACT_CPU_WRITE = 2'd0,
    ACT_PRG_READ  = 2'd1,
    ACT_CHR_READ  = 2'd2
  } action_t;

  // Mirroring codes reported with every result
  localparam logic [1:0] MIRROR_SINGLE     = 2'd0;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd1;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PRG_BANK_COUNT   = 1'b0;
  localparam logic CFG_RAM_OFFSET_UNITS = 1'b1;

  // Reset values
  localparam logic [4:0] SHIFT_EMPTY       = 5'h10;
  localparam logic [4:0] CONTROL_RESET     = 5'h0C;
  localparam logic [4:0] PRG_COUNT_RESET   = 5'd16;

  // Upper three address bits of the 8KB windows
  localparam logic [2:0] WIN_LOW     = 3'b000;
  localparam logic [2:0] WIN_RAM     = 3'b011;
  localparam logic [2:0] WIN_CONTROL = 3'b100;
  localparam logic [2:0] WIN_CHR_LO  = 3'b101;
  localparam logic [2:0] WIN_CHR_HI  = 3'b110;
  localparam logic [2:0] WIN_PRG     = 3'b111;

  localparam int ADDR_W   = 16;
  localparam int VALUE_W  = 8;
  localparam int MAPPED_W = 19;

  typedef struct packed {
    logic [4:0] shift;
    logic [4:0] control;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [4:0] prg;
  } state_t;

  typedef struct packed {
    logic [4:0] prg_bank_count;
    logic [2:0] ram_offset_units;
  } cfg_t;

  typedef struct packed {
    action_t              action;
    logic [ADDR_W-1:0]    bus_address;
    logic [VALUE_W-1:0]   write_value;
  } item_t;

  typedef struct packed {
    logic [MAPPED_W-1:0] mapped_address;
    logic                address_valid;
    logic                in_ram;
    logic [1:0]          mirror_mode;
  } result_t;

endpackage

// ===== hdl/sbsm_core.sv =====
module sbsm_core (
  input  sbsm_pkg::state_t  st,
  input  sbsm_pkg::cfg_t    cfg,
  input  sbsm_pkg::item_t   item,
  output sbsm_pkg::state_t  st_next,
  output sbsm_pkg::result_t res
);
  import sbsm_pkg::*;

  logic [2:0]          win;
  logic                in_window;
  logic [4:0]          shift_in;
  logic [1:0]          prg_mode;
  logic                low_half;
  logic [4:0]          last_bank;
  logic [4:0]          prg_bank_sel;
  logic [14:0]         prg_off;
  logic [MAPPED_W-1:0] prg_addr;
  logic [MAPPED_W-1:0] chr_addr;

  assign win       = item.bus_address[15:13];
  assign in_window = (win == WIN_RAM);
  assign shift_in  = {item.write_value[0], st.shift[4:1]};
  assign prg_mode  = st.control[3:2];
  assign low_half  = ~item.bus_address[14];
  assign last_bank = (cfg.prg_bank_count == 5'd0) ? 5'd0 : cfg.prg_bank_count - 5'd1;

  // Program bank and offset inside the selected bank
  always_comb begin
    unique case (prg_mode)
      2'd0, 2'd1: begin
        prg_bank_sel = {1'b0, st.prg[3:1], 1'b0};
        prg_off      = item.bus_address[14:0];
      end
      2'd2: begin
        prg_bank_sel = low_half ? 5'd0 : {1'b0, st.prg[3:0]};
        prg_off      = {1'b0, item.bus_address[13:0]};
      end
      default: begin
        prg_bank_sel = low_half ? {1'b0, st.prg[3:0]} : last_bank;
        prg_off      = {1'b0, item.bus_address[13:0]};
      end
    endcase
  end

  assign prg_addr = {prg_bank_sel, 14'd0} + MAPPED_W'(prg_off)
                  + MAPPED_W'({cfg.ram_offset_units, 13'd0});

  // Pattern table: one 8KB bank or two 4KB banks
  always_comb begin
    if (!st.control[4]) begin
      chr_addr = MAPPED_W'({st.chr_lo[4:1], item.bus_address[12:0]});
    end else if (!item.bus_address[12]) begin
      chr_addr = MAPPED_W'({st.chr_lo, item.bus_address[11:0]});
    end else begin
      chr_addr = MAPPED_W'({st.chr_hi, item.bus_address[11:0]});
    end
  end

  always_comb begin
    st_next            = st;
    res.mapped_address = '0;
    res.address_valid  = 1'b0;
    res.in_ram         = 1'b0;
    unique case (item.action)
      ACT_CPU_WRITE: begin
        if (in_window) begin
          res.mapped_address = MAPPED_W'(item.bus_address[12:0]);
          res.address_valid  = 1'b1;
          res.in_ram         = 1'b1;
        end else if (item.write_value[7]) begin
          st_next.shift   = SHIFT_EMPTY;
          st_next.control = st.control | CONTROL_RESET;
        end else if (st.shift[0]) begin
          // fifth bit: load the register chosen by the address window
          unique case (win)
            WIN_CONTROL: st_next.control = shift_in;
            WIN_CHR_LO:  st_next.chr_lo  = shift_in;
            WIN_CHR_HI:  st_next.chr_hi  = shift_in;
            WIN_PRG:     st_next.prg     = shift_in;
            default: ;
          endcase
          st_next.shift = SHIFT_EMPTY;
        end else begin
          st_next.shift = shift_in;
        end
      end
      ACT_PRG_READ: begin
        if (in_window) begin
          res.mapped_address = MAPPED_W'(item.bus_address[12:0]);
          res.address_valid  = 1'b1;
          res.in_ram         = 1'b1;
        end else if (item.bus_address[15]) begin
          res.mapped_address = prg_addr;
          res.address_valid  = 1'b1;
        end
      end
      ACT_CHR_READ: begin
        if (win == WIN_LOW) begin
          res.mapped_address = chr_addr;
          res.address_valid  = 1'b1;
        end
      end
      default: ;
    endcase

    // Mirroring follows the control value left by this access
    unique case (st_next.control[1:0])
      2'b10:   res.mirror_mode = MIRROR_VERTICAL;
      2'b11:   res.mirror_mode = MIRROR_HORIZONTAL;
      default: res.mirror_mode = MIRROR_SINGLE;
    endcase
  end

endmodule

// ===== hdl/serial_bank_switch_mapper.sv =====
// Serial-loaded bank switching mapper.
//
// Slave side (s_*): one request per bus access. s_tuser carries the access
// kind (CPU write, program fetch, pattern fetch); s_tdata carries the bus
// address and the CPU write byte.
// Master side (m_*): exactly one result per request, in request order:
// the mapped storage offset and mirroring mode in m_tdata, the valid and
// RAM-window flags in m_tuser.
// Configuration: cfg_we/cfg_index/cfg_data write the program bank count and
// the RAM offset unit count; write them only while no request is in flight.
//
// A request passes the input register, then the translation and
// register-update logic feeding the result register, before m_tvalid.
// Throughput is one request per cycle while m_tready is high; the serial
// register and bank registers update as a request moves into the result
// register, so consecutive requests see each other's writes in order.
// Reset (rst, synchronous) empties both stages and restores the mapper
// registers and configuration to their power-up values. When m_tready is
// low the result holds, the input stage still takes one more request, and
// s_tready then drops until the result is taken.
module serial_bank_switch_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_value
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [18:0] mapped_address, [20:19] mirror_mode, [23:21] zero
  output logic [1:0]  m_tuser,   // [0] address_valid, [1] in_ram
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import sbsm_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  state_t  st;
  state_t  st_next;
  cfg_t    cfg;
  result_t res_next;
  logic    advance;

  // Move the held request forward whenever the result slot is free or drains
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action      <= action_t'(s_tuser);
      in_item.bus_address <= s_tdata[15:0];
      in_item.write_value <= s_tdata[23:16];
    end
  end

  sbsm_core u_core (
    .st      (st),
    .cfg     (cfg),
    .item    (in_item),
    .st_next (st_next),
    .res     (res_next)
  );

  // Mapper registers: commit only when the request leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st.shift   <= SHIFT_EMPTY;
      st.control <= CONTROL_RESET;
      st.chr_lo  <= '0;
      st.chr_hi  <= '0;
      st.prg     <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_bank_count   <= PRG_COUNT_RESET;
      cfg.ram_offset_units <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRG_BANK_COUNT:   cfg.prg_bank_count   <= cfg_data;
        CFG_RAM_OFFSET_UNITS: cfg.ram_offset_units <= cfg_data[2:0];
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_res.mirror_mode, out_res.mapped_address};
  assign m_tuser  = {out_res.in_ram, out_res.address_valid};

  // An unmapped result carries a zero offset
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.address_valid) |-> (out_res.mapped_address == '0))
    else $error("unmapped result with nonzero offset");

  // RAM window hits are always mapped
  a_ram_is_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.in_ram) |-> out_res.address_valid)
    else $error("RAM window result without address_valid");

  // The serial register always keeps its marker bit somewhere
  a_shift_marker: assert property (@(posedge clk) disable iff (rst)
    st.shift != 5'd0)
    else $error("serial shift register lost its marker");

  // An empty result slot never blocks the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty result register");

  // Mapper registers change only when a request advances
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(st))
    else $error("mapper registers changed without a request");

endmodule

// ===== sim/serial_bank_switch_mapper_check.sv =====
`timescale 1ns / 100ps

module mapper_check
  import sbsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_value
  input  logic [1:0]  s_tuser,   // [1:0] action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [18:0] mapped_address, [20:19] mirror_mode, [23:21] zero
  input  logic [1:0]  m_tuser,   // [0] address_valid, [1] in_ram
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output int          errors,
  output int          awaiting
);

  // Mirror of the mapper registers and configuration
  logic [4:0] shift_q;
  logic [4:0] control_q;
  logic [4:0] chr_lo_q;
  logic [4:0] chr_hi_q;
  logic [4:0] prg_q;
  logic [4:0] bank_count;
  logic [2:0] ram_units;

  result_t mapped_results[$];
  int      miss_count = 0;
  int      pending_n  = 0;

  assign errors   = miss_count;
  assign awaiting = pending_n;

  task automatic report_mismatch(input string msg);
    miss_count++;
    $display("mismatch: %s", msg);
  endtask

  // Serial load: a set bit 7 empties the shift register and forces PRG mode 3.
  function automatic void load_serial(input logic [15:0] addr, input logic [7:0] val);
    logic [4:0] filled;
    filled = {val[0], shift_q[4:1]};
    if (val[7]) begin
      shift_q   = SHIFT_EMPTY;
      control_q = control_q | 5'h0C;
    end else if (shift_q[0]) begin
      case (addr[15:13])
        WIN_CONTROL: control_q = filled;
        WIN_CHR_LO:  chr_lo_q  = filled;
        WIN_CHR_HI:  chr_hi_q  = filled;
        WIN_PRG:     prg_q     = filled;
        default: ;
      endcase
      shift_q = SHIFT_EMPTY;
    end else begin
      shift_q = filled;
    end
  endfunction

  function automatic logic [18:0] prg_offset(input logic [15:0] addr);
    logic [31:0] base;
    logic [31:0] off;
    logic [31:0] last_bank;
    last_bank = (bank_count == 5'd0) ? 32'd0 : 32'(bank_count) - 32'd1;
    if (!control_q[3]) begin
      base = 32'(prg_q & 5'h0E) * 32'h4000;
      off  = 32'(addr) - 32'h8000;
    end else begin
      off = 32'(addr[13:0]);
      if (addr < 16'hC000)
        base = control_q[2] ? 32'(prg_q & 5'h0F) * 32'h4000 : 32'd0;
      else
        base = control_q[2] ? last_bank * 32'h4000 : 32'(prg_q & 5'h0F) * 32'h4000;
    end
    return 19'(off + base + 32'(ram_units) * 32'h2000);
  endfunction

  function automatic logic [18:0] chr_offset(input logic [15:0] addr);
    logic [31:0] sum;
    if (!control_q[4])
      sum = 32'(addr) + 32'(chr_lo_q & 5'h1E) * 32'h1000;
    else if (addr <= 16'h0FFF)
      sum = 32'(addr) + 32'(chr_lo_q) * 32'h1000;
    else
      sum = 32'(addr[11:0]) + 32'(chr_hi_q) * 32'h1000;
    return 19'(sum);
  endfunction

  // Translate one bus access and apply its register side effects.
  function automatic result_t map_access(input logic [1:0] act, input logic [15:0] addr,
                                         input logic [7:0] val);
    result_t r;
    logic    ram_hit;
    r = '0;
    ram_hit = (addr[15:13] == WIN_RAM);
    case (action_t'(act))
      ACT_CPU_WRITE: begin
        if (ram_hit) begin
          r.mapped_address = 19'(addr - 16'h6000);
          r.address_valid  = 1'b1;
          r.in_ram         = 1'b1;
        end else begin
          load_serial(addr, val);
        end
      end
      ACT_PRG_READ: begin
        if (ram_hit) begin
          r.mapped_address = 19'(addr - 16'h6000);
          r.address_valid  = 1'b1;
          r.in_ram         = 1'b1;
        end else if (addr[15]) begin
          r.mapped_address = prg_offset(addr);
          r.address_valid  = 1'b1;
        end
      end
      ACT_CHR_READ: begin
        if (addr < 16'h2000) begin
          r.mapped_address = chr_offset(addr);
          r.address_valid  = 1'b1;
        end
      end
      default: ;
    endcase
    case (control_q[1:0])
      2'd2:    r.mirror_mode = MIRROR_VERTICAL;
      2'd3:    r.mirror_mode = MIRROR_HORIZONTAL;
      default: r.mirror_mode = MIRROR_SINGLE;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shift_q    = SHIFT_EMPTY;
      control_q  = CONTROL_RESET;
      chr_lo_q   = 5'd0;
      chr_hi_q   = 5'd0;
      prg_q      = 5'd0;
      bank_count = PRG_COUNT_RESET;
      ram_units  = 3'd0;
      mapped_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PRG_BANK_COUNT) bank_count = cfg_data;
        else ram_units = cfg_data[2:0];
      end
      // Compare before pushing: a result never belongs to a same-edge request.
      if (m_tvalid && m_tready) begin
        if (mapped_results.size() == 0) begin
          report_mismatch($sformatf("result %h/%h with no request waiting", m_tdata, m_tuser));
        end else begin
          want = mapped_results.pop_front();
          if (m_tdata[18:0] !== want.mapped_address)
            report_mismatch($sformatf("mapped_address got %h want %h",
                                      m_tdata[18:0], want.mapped_address));
          if (m_tdata[20:19] !== want.mirror_mode)
            report_mismatch($sformatf("mirror_mode got %0d want %0d",
                                      m_tdata[20:19], want.mirror_mode));
          if (m_tdata[23:21] !== 3'd0)
            report_mismatch($sformatf("tdata padding got %b", m_tdata[23:21]));
          if (m_tuser[0] !== want.address_valid)
            report_mismatch($sformatf("address_valid got %b want %b",
                                      m_tuser[0], want.address_valid));
          if (m_tuser[1] !== want.in_ram)
            report_mismatch($sformatf("in_ram got %b want %b", m_tuser[1], want.in_ram));
        end
      end
      if (s_tvalid && s_tready)
        mapped_results.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
    end
    pending_n = mapped_results.size();
  end

endmodule

// ===== sim/serial_bank_switch_mapper_tb.sv =====
`timescale 1ns / 100ps

module serial_bank_switch_mapper_tb;
  import sbsm_pkg::*;

  // Action code the block must treat as a no-op
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 212;
  // Long receiver hold-off, placed in the phase where nobody idles
  localparam int STALL_AT    = 1450;
  localparam int STALL_LEN   = 60;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // [15:0] bus_address, [23:16] write_value
  logic [1:0]  s_tuser;    // [1:0] action
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [18:0] mapped_address, [20:19] mirror_mode, [23:21] zero
  logic [1:0]  m_tuser;    // [0] address_valid, [1] in_ram
  logic        cfg_we;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  int errors;
  int awaiting;
  int cycle_n       = 0;
  int items_sent    = 0;
  int src_idle_pct  = 13;
  int sink_idle_pct = 87;
  int hold_left     = 0;
  bit stall_done    = 0;

  // Bank count / RAM unit settings per phase: extremes, zero count, wrap-around
  logic [4:0] phase_count [PHASES] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd8, 5'd2, 5'd16, 5'd5};
  logic [2:0] phase_units [PHASES] = '{3'd0, 3'd4, 3'd4, 3'd7, 3'd2, 3'd1, 3'd0, 3'd3};
  logic [2:0] reg_windows [4]      = '{WIN_CONTROL, WIN_CHR_LO, WIN_CHR_HI, WIN_PRG};

  serial_bank_switch_mapper uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mapper_check access_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .awaiting  (awaiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: abort a hung run
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off so the block
  // fills both stages and drops s_tready while requests keep coming.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_done && items_sent >= STALL_AT) begin
        hold_left  = STALL_LEN;
        stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offer one request; hold it until accepted. Enter and leave at a falling edge.
  task automatic send_access(input logic [1:0] act, input logic [15:0] addr,
                             input logic [7:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {val, addr};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Drain all results, let the pipeline settle, then write both registers.
  task automatic write_settings(input logic [4:0] count, input logic [2:0] units);
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRG_BANK_COUNT;
    cfg_data  <= count;
    @(negedge clk);
    cfg_index <= CFG_RAM_OFFSET_UNITS;
    cfg_data  <= {2'b00, units};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_prg_read();
    int r;
    r = $urandom_range(99);
    if (r < 75)      send_access(ACT_PRG_READ, {1'b1, 15'($urandom)}, 8'($urandom));
    else if (r < 90) send_access(ACT_PRG_READ, {WIN_RAM, 13'($urandom)}, 8'($urandom));
    else             send_access(ACT_PRG_READ, 16'($urandom), 8'($urandom));
  endtask

  // Mostly complete five-write serial loads with random content, mixed with
  // translations; the rest is noise, undefined actions and broken loads.
  task automatic run_random(input int n);
    int          start;
    int          r;
    logic [2:0]  win;
    start = items_sent;
    while (items_sent - start < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        if ($urandom_range(9) < 8) win = reg_windows[$urandom_range(3)];
        else win = WIN_LOW + 3'($urandom_range(2));
        if ($urandom_range(3) == 0)
          send_access(ACT_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
        for (int k = 0; k < 5; k++) begin
          if ($urandom_range(7) == 0) send_prg_read();
          // occasionally abort the load part way
          if ($urandom_range(15) == 0)
            send_access(ACT_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
          send_access(ACT_CPU_WRITE, {win, 13'($urandom)}, {1'b0, 7'($urandom)});
        end
      end else if (r < 60) begin
        send_prg_read();
      end else if (r < 85) begin
        if ($urandom_range(6) != 0)
          send_access(ACT_CHR_READ, {3'b000, 13'($urandom)}, 8'($urandom));
        else
          send_access(ACT_CHR_READ, 16'($urandom), 8'($urandom));
      end else if (r < 92) begin
        send_access(ACT_CPU_WRITE, {WIN_RAM, 13'($urandom)}, 8'($urandom));
      end else if (r < 96) begin
        send_access(ACT_UNDEFINED, 16'($urandom), 8'($urandom));
      end else begin
        send_access(2'($urandom_range(2)), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = ACT_CPU_WRITE;
    cfg_we    = 1'b0;
    cfg_index = CFG_PRG_BANK_COUNT;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: power-up mapping (mode 3, last bank fixed), window edges
    send_access(ACT_PRG_READ,  16'h8000, 8'h00);
    send_access(ACT_PRG_READ,  16'hFFFF, 8'hFF);
    send_access(ACT_CHR_READ,  16'h0000, 8'h00);
    send_access(ACT_CHR_READ,  16'h1FFF, 8'h00);
    send_access(ACT_CHR_READ,  16'h2000, 8'h00);  // beyond pattern space
    send_access(ACT_PRG_READ,  16'h5FFF, 8'h00);  // below the RAM window
    send_access(ACT_CPU_WRITE, 16'h7FFF, 8'hFF);  // RAM write leaves the shifter alone
    send_access(ACT_PRG_READ,  16'h6000, 8'h00);
    send_access(ACT_UNDEFINED, 16'hFFFF, 8'hFF);
    // Load control with 0x1B: horizontal mirroring, PRG mode 2, two 4KB CHR banks
    send_access(ACT_CPU_WRITE, 16'h8000, 8'h01);
    send_access(ACT_CPU_WRITE, 16'h9FFF, 8'h7F);
    send_access(ACT_CPU_WRITE, 16'h8000, 8'h00);
    send_access(ACT_CPU_WRITE, 16'h8123, 8'h01);
    send_access(ACT_CPU_WRITE, 16'h9FFF, 8'h41);
    send_access(ACT_PRG_READ,  16'hC000, 8'h00);
    send_access(ACT_CHR_READ,  16'h1000, 8'h00);
    // Load program bank with all ones
    send_access(ACT_CPU_WRITE, 16'hE000, 8'h01);
    send_access(ACT_CPU_WRITE, 16'hFFFF, 8'h01);
    send_access(ACT_CPU_WRITE, 16'hE000, 8'h01);
    send_access(ACT_CPU_WRITE, 16'hFFFF, 8'h01);
    send_access(ACT_CPU_WRITE, 16'hE001, 8'h01);
    send_access(ACT_PRG_READ,  16'hC000, 8'h00);
    // One bit in, then a reset write: empties the shifter, forces mode 3
    send_access(ACT_CPU_WRITE, 16'hA000, 8'h01);
    send_access(ACT_CPU_WRITE, 16'hFFFF, 8'h80);
    send_access(ACT_PRG_READ,  16'h8000, 8'h00);

    // Random phases: sender-light/receiver-heavy idling, then reversed, then none
    for (int p = 0; p < PHASES; p++) begin
      write_settings(phase_count[p], phase_units[p]);
      if (p < 3) begin
        src_idle_pct  = 13;
        sink_idle_pct = 87;
      end else if (p < 6) begin
        src_idle_pct  = 87;
        sink_idle_pct = 13;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      run_random(PHASE_ITEMS);
    end

    // Drop valid, wait for every result, then watch for strays
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
